// ===== rtl/cpd_pkg.sv =====
package cpd_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned COUNT_W = 27;
    localparam int unsigned ADDR_W  = 14;

    localparam int unsigned TYPE_HI   = 31;
    localparam int unsigned TYPE_LO   = 29;
    localparam int unsigned OP_HI     = 28;
    localparam int unsigned OP_LO     = 27;
    localparam int unsigned ADDR_HI   = 26;
    localparam int unsigned ADDR_LO   = 13;
    localparam int unsigned COUNT1_HI = 10;
    localparam int unsigned COUNT2_HI = 26;

    typedef enum logic [2:0] {
        WK_EMPTY   = 3'd0,
        WK_HEADER  = 3'd1,
        WK_DATA    = 3'd2,
        WK_DROPPED = 3'd3,
        WK_HALTED  = 3'd4
    } t_word_kind;

    localparam logic [2:0] PT_NOOP  = 3'd0;
    localparam logic [2:0] PT_SHORT = 3'd1;
    localparam logic [2:0] PT_LONG  = 3'd2;

    typedef struct packed {
        logic [COUNT_W-1:0] words_left;
        logic [1:0]         kind;
        logic [1:0]         opcode;
        logic [ADDR_W-1:0]  address;
        logic               emitted;
        logic               have_previous;
        logic               stopped;
    } t_state;

    typedef struct packed {
        t_word_kind        word_kind;
        logic [1:0]        packet_kind;
        logic [1:0]        packet_opcode;
        logic [ADDR_W-1:0] register_address;
        logic [WORD_W-1:0] payload_word;
        logic              last_in_packet;
    } t_result;

endpackage

// ===== rtl/cpd_if.sv =====
interface cpd_word_if import cpd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] stream_word;

    modport source (output valid, output stream_word, input ready);
    modport sink   (input valid, input stream_word, output ready);
endinterface

interface cpd_result_if import cpd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [2:0]        word_kind;
    logic [1:0]        packet_kind;
    logic [1:0]        packet_opcode;
    logic [ADDR_W-1:0] register_address;
    logic [WORD_W-1:0] payload_word;
    logic              last_in_packet;

    modport source (output valid, output word_kind, output packet_kind,
                    output packet_opcode, output register_address,
                    output payload_word, output last_in_packet, input ready);
    modport sink   (input valid, input word_kind, input packet_kind,
                    input packet_opcode, input register_address,
                    input payload_word, input last_in_packet, output ready);
endinterface

// ===== rtl/cpd_decode.sv =====
module cpd_decode import cpd_pkg::*; (
    input  t_state            i_state,
    input  logic [WORD_W-1:0] i_word,
    output t_state            o_state,
    output t_result           o_result
);

    logic [2:0]         w_type;
    logic [1:0]         w_op;
    logic [COUNT_W-1:0] w_count1;
    logic [COUNT_W-1:0] w_count2;

    assign w_type   = i_word[TYPE_HI:TYPE_LO];
    assign w_op     = i_word[OP_HI:OP_LO];
    assign w_count1 = {{(COUNT_W-COUNT1_HI-1){1'b0}}, i_word[COUNT1_HI:0]};
    assign w_count2 = i_word[COUNT2_HI:0];

    always_comb begin
        o_state  = i_state;
        o_result = '0;
        o_result.word_kind = WK_EMPTY;
        if (i_state.stopped) begin
            o_result.word_kind = WK_HALTED;
        end else if (i_state.words_left != '0) begin
            o_state.words_left      = i_state.words_left - COUNT_W'(1);
            o_result.packet_kind    = i_state.kind;
            o_result.packet_opcode  = i_state.opcode;
            o_result.last_in_packet = (i_state.words_left == COUNT_W'(1));
            if (i_state.emitted) begin
                o_result.word_kind        = WK_DATA;
                o_result.register_address = i_state.address;
                o_result.payload_word     = i_word;
            end else begin
                o_result.word_kind = WK_DROPPED;
            end
        end else begin
            case (w_type)
                PT_NOOP: begin
                    o_state.kind            = 2'd0;
                    o_state.opcode          = 2'd0;
                    o_state.address         = '0;
                    o_state.emitted         = 1'b1;
                    o_state.have_previous   = 1'b1;
                    o_result.last_in_packet = 1'b1;
                end
                PT_SHORT: begin
                    o_state.kind              = 2'd1;
                    o_state.opcode            = w_op;
                    o_state.address           = i_word[ADDR_HI:ADDR_LO];
                    o_state.emitted           = 1'b1;
                    o_state.have_previous     = 1'b1;
                    o_state.words_left        = w_count1;
                    o_result.word_kind        = (w_count1 != '0) ? WK_HEADER : WK_EMPTY;
                    o_result.packet_kind      = 2'd1;
                    o_result.packet_opcode    = w_op;
                    o_result.register_address = i_word[ADDR_HI:ADDR_LO];
                    o_result.last_in_packet   = (w_count1 == '0);
                end
                PT_LONG: begin
                    o_state.kind            = 2'd2;
                    o_state.opcode          = w_op;
                    o_state.words_left      = w_count2;
                    o_state.emitted         = i_state.have_previous;
                    o_result.word_kind      = (w_count2 != '0) ? WK_HEADER : WK_EMPTY;
                    o_result.packet_kind    = 2'd2;
                    o_result.packet_opcode  = w_op;
                    o_result.last_in_packet = (w_count2 == '0);
                    if (i_state.have_previous) begin
                        o_result.register_address = i_state.address;
                    end
                end
                default: begin
                    o_state.stopped    = 1'b1;
                    o_result.word_kind = WK_HALTED;
                end
            endcase
        end
    end

endmodule

// ===== rtl/config_packet_deframer.sv =====
// A result is presented in the cycle after its word is transferred in.
// Throughput: one word per cycle while the sink is ready; the result
// register reloads in the same cycle the previous result is transferred out.
// Reset: synchronous, active low; clears the packet state and the halt flag
// and empties the result register.
module config_packet_deframer import cpd_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    cpd_word_if.sink     i_word,
    cpd_result_if.source o_result
);

    t_state  r_state;
    t_state  n_state;
    t_result n_result;
    t_result r_result;
    logic    r_valid;
    logic    w_take;

    assign i_word.ready = !r_valid || o_result.ready;
    assign w_take       = i_word.valid && i_word.ready;

    cpd_decode u_decode (
        .i_state  (r_state),
        .i_word   (i_word.stream_word),
        .o_state  (n_state),
        .o_result (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
            r_valid <= 1'b0;
        end else begin
            if (w_take) begin
                r_state <= n_state;
                r_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_result <= n_result;
        end
    end

    assign o_result.valid            = r_valid;
    assign o_result.word_kind        = r_result.word_kind;
    assign o_result.packet_kind      = r_result.packet_kind;
    assign o_result.packet_opcode    = r_result.packet_opcode;
    assign o_result.register_address = r_result.register_address;
    assign o_result.payload_word     = r_result.payload_word;
    assign o_result.last_in_packet   = r_result.last_in_packet;

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import cpd_pkg::*;

    localparam int RANDOM_WORDS = 1300;
    localparam int IDLE_LIMIT   = 2000;
    localparam int HOLD_START   = 800;
    localparam int HOLD_CYCLES  = 150;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    cpd_word_if   word_bus ();
    cpd_result_if result_bus ();

    config_packet_deframer DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_word   (word_bus.sink),
        .o_result (result_bus.source)
    );

    always #6 i_clk = ~i_clk;

    logic [WORD_W-1:0]  word_queue[$];
    t_result            expected_results[$];
    int                 stimulus_total = 0;
    int                 words_sent = 0;
    int                 results_checked = 0;
    int                 error_count = 0;
    int                 kind_seen[5] = '{default: 0};

    logic [COUNT_W-1:0] data_left = '0;
    logic [1:0]         pkt_kind = '0;
    logic [1:0]         pkt_op = '0;
    logic [ADDR_W-1:0]  pkt_addr = '0;
    logic               pkt_kept = 1'b0;
    logic               seen_packet = 1'b0;
    logic               parser_halted = 1'b0;

    function automatic t_result deframe_word(input logic [WORD_W-1:0] w);
        t_result            r;
        logic [COUNT_W-1:0] cnt;
        r = '0;
        cnt = '0;
        if (parser_halted) begin
            r.word_kind = WK_HALTED;
            return r;
        end
        if (data_left != 0) begin
            data_left = data_left - COUNT_W'(1);
            r.packet_kind = pkt_kind;
            r.packet_opcode = pkt_op;
            r.last_in_packet = (data_left == 0);
            if (pkt_kept) begin
                r.word_kind = WK_DATA;
                r.register_address = pkt_addr;
                r.payload_word = w;
            end else begin
                r.word_kind = WK_DROPPED;
            end
            return r;
        end
        case (w[TYPE_HI:TYPE_LO])
            PT_NOOP: begin
                pkt_kind = 2'(PT_NOOP);
                pkt_op = '0;
                pkt_addr = '0;
                pkt_kept = 1'b1;
                seen_packet = 1'b1;
            end
            PT_SHORT: begin
                cnt = COUNT_W'(w[COUNT1_HI:0]);
                pkt_kind = 2'(PT_SHORT);
                pkt_op = w[OP_HI:OP_LO];
                pkt_addr = w[ADDR_HI:ADDR_LO];
                pkt_kept = 1'b1;
                seen_packet = 1'b1;
            end
            PT_LONG: begin
                cnt = w[COUNT2_HI:0];
                pkt_kind = 2'(PT_LONG);
                pkt_op = w[OP_HI:OP_LO];
                pkt_kept = seen_packet;
            end
            default: begin
                parser_halted = 1'b1;
                data_left = '0;
                r.word_kind = WK_HALTED;
                return r;
            end
        endcase
        data_left = cnt;
        if (cnt != 0) begin
            r.word_kind = WK_HEADER;
        end else begin
            r.word_kind = WK_EMPTY;
        end
        r.packet_kind = pkt_kind;
        r.packet_opcode = pkt_op;
        r.register_address = pkt_kept ? pkt_addr : '0;
        r.last_in_packet = (cnt == 0);
        return r;
    endfunction

    function automatic logic [WORD_W-1:0] random_payload();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_packet(input logic [WORD_W-1:0] header, input int count);
        word_queue.push_back(header);
        repeat (count) word_queue.push_back(random_payload());
    endtask

    function automatic logic [WORD_W-1:0] short_header(input logic [1:0] op,
                                                       input logic [ADDR_W-1:0] addr,
                                                       input int count);
        return {PT_SHORT, op, addr, 2'($urandom), 11'(count)};
    endfunction

    function automatic logic [WORD_W-1:0] long_header(input logic [1:0] op, input int count);
        return {PT_LONG, op, COUNT_W'(count)};
    endfunction

    initial begin
        int pick;
        int count;
        int directed_count;

        // A long packet before any other packet has its data dropped.
        word_queue.push_back(long_header(2'd1, 2));
        word_queue.push_back('1);
        word_queue.push_back('0);
        add_packet(long_header(2'd3, 0), 0);
        add_packet('0, 0);
        add_packet({PT_NOOP, 29'h1FFF_FFFF}, 0);
        add_packet(long_header(2'd2, 1), 1);
        add_packet(short_header(2'd0, 14'h3FFF, 0), 0);
        add_packet(short_header(2'd1, 14'h2AAA, 3), 3);
        add_packet(long_header(2'd3, 2), 2);
        add_packet(short_header(2'd2, 14'h1555, 1), 1);
        add_packet(long_header(2'd0, 0), 0);
        directed_count = word_queue.size();

        while (word_queue.size() < directed_count + RANDOM_WORDS) begin
            pick = $urandom_range(0, 99);
            count = $urandom_range(0, 9);
            if (count < 3) begin
                count = 0;
            end else if (count < 9) begin
                count = $urandom_range(1, 6);
            end else begin
                count = $urandom_range(7, 40);
            end
            if (pick < 15) begin
                add_packet({PT_NOOP, 29'($urandom)}, 0);
            end else if (pick < 60) begin
                add_packet(short_header(2'($urandom), 14'($urandom), count), count);
            end else begin
                add_packet(long_header(2'($urandom), count), count);
            end
        end

        // The halt is final, so it is the last header; the words after it come out halted.
        word_queue.push_back({3'($urandom_range(3, 7)), 29'($urandom)});
        repeat (4) word_queue.push_back($urandom);
        stimulus_total = word_queue.size();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (words_sent < stimulus_total || expected_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        $display("Sent %0d words; checked %0d results: %0d empty headers, %0d headers,",
                 words_sent, results_checked, kind_seen[WK_EMPTY], kind_seen[WK_HEADER]);
        $display("%0d data, %0d dropped, %0d halted words; %0d errors.",
                 kind_seen[WK_DATA], kind_seen[WK_DROPPED], kind_seen[WK_HALTED], error_count);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    int burst_left = 1;
    int gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            word_bus.valid <= 1'b0;
        end else begin
            if (word_bus.valid && word_bus.ready) begin
                expected_results.push_back(deframe_word(word_bus.stream_word));
                words_sent++;
            end
            if (!word_bus.valid || word_bus.ready) begin
                if (gap_left != 0 || word_queue.size() == 0) begin
                    word_bus.valid <= 1'b0;
                    if (gap_left != 0) gap_left--;
                end else begin
                    word_bus.valid <= 1'b1;
                    word_bus.stream_word <= word_queue.pop_front();
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left--;
                    end
                end
            end
        end
    end

    int          sink_cycle = 0;
    int          hold_left = 0;
    logic [15:0] stall_pattern = '1;
    int          pattern_step = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            result_bus.ready <= 1'b0;
        end else begin
            sink_cycle++;
            if (sink_cycle == HOLD_START) hold_left = HOLD_CYCLES;
            if (hold_left != 0) begin
                result_bus.ready <= 1'b0;
                hold_left--;
            end else begin
                result_bus.ready <= stall_pattern[0];
                stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
                pattern_step++;
                if (pattern_step == 16) begin
                    pattern_step = 0;
                    case ($urandom_range(0, 3))
                        0: stall_pattern = '1;
                        1: stall_pattern = 16'($urandom);
                        2: stall_pattern = 16'($urandom) | 16'($urandom);
                        default: stall_pattern = 16'($urandom) & 16'($urandom) | 16'h0001;
                    endcase
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && result_bus.valid && result_bus.ready) begin
            got.word_kind = t_word_kind'(result_bus.word_kind);
            got.packet_kind = result_bus.packet_kind;
            got.packet_opcode = result_bus.packet_opcode;
            got.register_address = result_bus.register_address;
            got.payload_word = result_bus.payload_word;
            got.last_in_packet = result_bus.last_in_packet;
            if (expected_results.size() == 0) begin
                error_count++;
                if (error_count <= 10)
                    $display("Unexpected result transfer: kind %0d addr %h data %h",
                             got.word_kind, got.register_address, got.payload_word);
            end else begin
                want = expected_results.pop_front();
                results_checked++;
                if (want.word_kind <= WK_HALTED) kind_seen[want.word_kind]++;
                if (got !== want) begin
                    error_count++;
                    if (error_count <= 10)
                        $display({"Mismatch on result %0d: expected kind %0d type %0d op %0d ",
                                  "addr %h data %h last %0d, got kind %0d type %0d op %0d ",
                                  "addr %h data %h last %0d"},
                                 results_checked, want.word_kind, want.packet_kind,
                                 want.packet_opcode, want.register_address, want.payload_word,
                                 want.last_in_packet, got.word_kind, got.packet_kind,
                                 got.packet_opcode, got.register_address, got.payload_word,
                                 got.last_in_packet);
                end
            end
        end
    end

    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if ((word_bus.valid && word_bus.ready) || (result_bus.valid && result_bus.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timed out after %0d cycles without a transfer.", IDLE_LIMIT);
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

// ===== files.f =====
rtl/cpd_pkg.sv
rtl/cpd_if.sv
rtl/cpd_decode.sv
rtl/config_packet_deframer.sv
verif/testbench.sv
